@@ rtl/core/tcp_connection_fsm_macros.svh @@
// Assertion macros used by the TCP connection tracker RTL.
// Each macro expects a clk and an active-low rst_n in the enclosing module.
`ifndef TCP_CONNECTION_FSM_MACROS_SVH
`define TCP_CONNECTION_FSM_MACROS_SVH

// Same-cycle implication.
`define TCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tcf_pkg.sv @@
// Types, codes and constants for the TCP connection tracker.
// Used by every module under rtl/core; depends on nothing.
package tcf_pkg;

  localparam int unsigned IN_TDATA_W  = 152;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned MAX_RES     = 3;
  localparam logic [15:0] DEFAULT_MSS_RST = 16'd536;

  typedef enum logic [1:0] {
    CMD_OPEN    = 2'd0,
    CMD_CLOSE   = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_SEGMENT = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLOSED     = 4'd0,
    ST_SYN_SENT   = 4'd1,
    ST_SYN_RCVD   = 4'd2,
    ST_ESTAB      = 4'd3,
    ST_FIN_WAIT1  = 4'd4,
    ST_FIN_WAIT2  = 4'd5,
    ST_CLOSE_WAIT = 4'd6,
    ST_CLOSING    = 4'd7,
    ST_LAST_ACK   = 4'd8,
    ST_ERROR      = 4'd9
  } conn_state_t;

  typedef enum logic [2:0] {
    PK_NONE    = 3'd0,
    PK_SYN     = 3'd1,
    PK_ACK     = 3'd2,
    PK_FIN     = 3'd3,
    PK_SYN_ACK = 3'd4
  } pkt_kind_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_CONNECTED = 3'd1,
    EV_CONN_ERR  = 3'd2,
    EV_CLOSED    = 3'd3,
    EV_OOO       = 3'd4
  } event_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] initial_seq;
    logic        seg_syn;
    logic        seg_ack;
    logic        seg_fin;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack_num;
    logic [15:0] seg_window;
    logic [15:0] payload_len;
    logic        mss_opt_present;
    logic [15:0] mss_opt_value;
    logic        send_data_pending;
  } in_item_t;

  typedef struct packed {
    pkt_kind_t   pkt;
    logic [31:0] seq;
    logic [31:0] ack;
    event_t      ev;
  } res_t;

  // All result words caused by one input word.
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         cnt;
    conn_state_t        st;
    logic               acc;
  } batch_t;

endpackage

@@ rtl/core/tcf_in_reg.sv @@
// Input register for the TCP connection tracker: unpacks the slave stream word.
// Depends on tcf_pkg.
module tcf_in_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tcf_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [1:0]                     in_tuser,
  output tcf_pkg::in_item_t              itm,
  output logic                           itm_vld,
  input  logic                           itm_take
);
  import tcf_pkg::*;

  logic     vld_r;
  in_item_t itm_r;
  in_item_t itm_nxt;

  assign in_tready = !vld_r || itm_take;
  assign itm       = itm_r;
  assign itm_vld   = vld_r;

  always_comb begin
    itm_nxt.cmd               = cmd_t'(in_tuser);
    itm_nxt.initial_seq       = in_tdata[31:0];
    itm_nxt.seg_syn           = in_tdata[32];
    itm_nxt.seg_ack           = in_tdata[33];
    itm_nxt.seg_fin           = in_tdata[34];
    itm_nxt.seg_seq           = in_tdata[66:35];
    itm_nxt.seg_ack_num       = in_tdata[98:67];
    itm_nxt.seg_window        = in_tdata[114:99];
    itm_nxt.payload_len       = in_tdata[130:115];
    itm_nxt.mss_opt_present   = in_tdata[131];
    itm_nxt.mss_opt_value     = in_tdata[147:132];
    itm_nxt.send_data_pending = in_tdata[148];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      vld_r <= 1'b1;
    end else if (itm_take) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      itm_r <= itm_nxt;
    end
  end

endmodule

@@ rtl/core/tcf_step.sv @@
// Connection state registers, next-state logic and the single-pass result logic
// that turns one input word into a batch of result words. Depends on tcf_pkg.
module tcf_step (
  input  logic              clk,
  input  logic              rst_n,
  input  tcf_pkg::in_item_t itm,
  input  logic              ld,
  input  logic [15:0]       dflt_mss,
  output tcf_pkg::batch_t   bat
);
  import tcf_pkg::*;

  conn_state_t st_r, st_nxt;
  logic [31:0] send_seq_r, send_seq_nxt;
  logic [31:0] expect_seq_r, expect_seq_nxt;
  logic [31:0] peer_seq_r, peer_seq_nxt;
  logic [31:0] ack_seen_r, ack_seen_nxt;
  logic [1:0]  dup_r, dup_nxt;
  logic [15:0] peer_win_r, peer_win_nxt;
  logic [15:0] seg_size_r, seg_size_nxt;

  logic [31:0]        diff_c;
  logic               ahead_c;
  logic               seg_go_c;
  logic               syn_hit_c;
  logic               fin_hit_c;
  logic [31:0]        syn_ack_c;
  conn_state_t        mid_st_c;
  res_t [MAX_RES-1:0] res_c;
  logic [1:0]         n_c;
  logic               acc_c;

  // Segment lies ahead of the next expected byte (modular compare).
  assign diff_c  = itm.seg_seq - expect_seq_r;
  assign ahead_c = (diff_c != 32'd0) && !diff_c[31];

  // Segment taken by a live connection; in estab only if it does not lie ahead.
  assign seg_go_c  = (itm.cmd == CMD_SEGMENT) && (st_r != ST_CLOSED) && (st_r != ST_ERROR) &&
                     !(st_r == ST_ESTAB && ahead_c);
  assign syn_hit_c = seg_go_c && itm.seg_syn && (st_r == ST_SYN_SENT);
  assign fin_hit_c = seg_go_c && itm.seg_fin;
  assign syn_ack_c = itm.seg_seq + 32'd1;

  // State seen by the FIN handling: after the syn_rcvd and SYN updates
  always_comb begin
    if (syn_hit_c) begin
      mid_st_c = itm.seg_ack ? ST_ESTAB : ST_SYN_RCVD;
    end else if (st_r == ST_SYN_RCVD) begin
      mid_st_c = ST_ESTAB;
    end else begin
      mid_st_c = st_r;
    end
  end

  // Next state
  always_comb begin
    st_nxt         = st_r;
    send_seq_nxt   = send_seq_r;
    expect_seq_nxt = expect_seq_r;
    peer_seq_nxt   = peer_seq_r;
    ack_seen_nxt   = ack_seen_r;
    dup_nxt        = dup_r;
    peer_win_nxt   = peer_win_r;
    seg_size_nxt   = seg_size_r;

    case (itm.cmd)
      CMD_OPEN: begin
        if (st_r == ST_CLOSED || st_r == ST_ERROR) begin
          send_seq_nxt   = itm.initial_seq;
          expect_seq_nxt = '0;
          peer_seq_nxt   = '0;
          ack_seen_nxt   = '0;
          dup_nxt        = '0;
          peer_win_nxt   = '0;
          seg_size_nxt   = dflt_mss;
          st_nxt         = ST_SYN_SENT;
        end
      end
      CMD_CLOSE: begin
        if (st_r == ST_ESTAB || st_r == ST_SYN_RCVD || st_r == ST_CLOSE_WAIT) begin
          st_nxt       = (st_r == ST_CLOSE_WAIT) ? ST_LAST_ACK : ST_FIN_WAIT1;
          send_seq_nxt = send_seq_r + 32'd1;
        end else if (st_r != ST_CLOSED && st_r != ST_ERROR) begin
          st_nxt = ST_ERROR;
        end
      end
      CMD_TIMEOUT: begin
        if (st_r == ST_SYN_SENT || st_r == ST_SYN_RCVD) begin
          st_nxt = ST_ERROR;
        end
      end
      CMD_SEGMENT: begin
        if (seg_go_c) begin
          peer_seq_nxt   = itm.seg_seq;
          expect_seq_nxt = itm.seg_seq + {16'd0, itm.payload_len};
          if (st_r == ST_ESTAB && ack_seen_r == itm.seg_ack_num) begin
            if (dup_r != 2'd3) begin
              dup_nxt = dup_r + 2'd1;
            end
          end else begin
            ack_seen_nxt = itm.seg_ack_num;
            dup_nxt      = 2'd1;
          end
          peer_win_nxt = itm.seg_window;
          st_nxt       = mid_st_c;

          if (syn_hit_c) begin
            if (itm.mss_opt_present) begin
              seg_size_nxt = itm.mss_opt_value;
            end
            expect_seq_nxt = syn_ack_c;
            send_seq_nxt   = send_seq_r + 32'd1;
          end

          if (fin_hit_c) begin
            case (mid_st_c)
              ST_SYN_SENT, ST_SYN_RCVD: begin
                st_nxt = ST_ERROR;
              end
              ST_FIN_WAIT1, ST_FIN_WAIT2, ST_CLOSING, ST_LAST_ACK: begin
                // fin_wait1 without ACK waits in closing; the rest are done
                expect_seq_nxt = expect_seq_nxt + 32'd1;
                st_nxt = (mid_st_c == ST_FIN_WAIT1 && !itm.seg_ack) ? ST_CLOSING : ST_CLOSED;
              end
              ST_ESTAB, ST_CLOSE_WAIT: begin
                expect_seq_nxt = expect_seq_nxt + 32'd1;
                st_nxt = itm.send_data_pending ? ST_CLOSE_WAIT : ST_CLOSED;
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result words
  always_comb begin
    res_c = '0;
    n_c   = 2'd0;
    acc_c = 1'b0;

    case (itm.cmd)
      CMD_OPEN: begin
        if (st_r == ST_CLOSED || st_r == ST_ERROR) begin
          res_c[0] = '{pkt: PK_SYN, seq: send_seq_nxt, ack: expect_seq_nxt, ev: EV_NONE};
          n_c      = 2'd1;
        end
      end
      CMD_CLOSE: begin
        if (st_r == ST_ESTAB || st_r == ST_SYN_RCVD || st_r == ST_CLOSE_WAIT) begin
          res_c[0] = '{pkt: PK_FIN, seq: send_seq_r, ack: expect_seq_r, ev: EV_NONE};
          n_c      = 2'd1;
        end else if (st_r != ST_CLOSED && st_r != ST_ERROR) begin
          res_c[0] = '{pkt: PK_NONE, seq: send_seq_r, ack: expect_seq_r, ev: EV_CLOSED};
          n_c      = 2'd1;
        end
      end
      CMD_TIMEOUT: begin
        if (st_r == ST_SYN_SENT || st_r == ST_SYN_RCVD) begin
          res_c[0] = '{pkt: PK_NONE, seq: send_seq_r, ack: expect_seq_r, ev: EV_CONN_ERR};
          n_c      = 2'd1;
        end
      end
      CMD_SEGMENT: begin
        if (st_r == ST_ESTAB && ahead_c) begin
          res_c[0] = '{pkt: PK_ACK, seq: send_seq_r, ack: expect_seq_r, ev: EV_OOO};
          n_c      = 2'd1;
        end

        if (syn_hit_c) begin
          res_c[n_c] = '{pkt: PK_ACK, seq: send_seq_nxt, ack: syn_ack_c,
                         ev: (itm.seg_ack ? EV_CONNECTED : EV_NONE)};
          n_c        = n_c + 2'd1;
        end

        // every FIN answer carries the final sequence numbers of the step
        if (fin_hit_c) begin
          case (mid_st_c)
            ST_SYN_SENT, ST_SYN_RCVD: begin
              res_c[n_c] = '{pkt: PK_FIN, seq: send_seq_nxt, ack: expect_seq_nxt,
                             ev: EV_CONN_ERR};
              n_c        = n_c + 2'd1;
            end
            ST_FIN_WAIT1, ST_FIN_WAIT2, ST_CLOSING, ST_LAST_ACK: begin
              res_c[n_c] = '{pkt: PK_ACK, seq: send_seq_nxt, ack: expect_seq_nxt,
                             ev: ((mid_st_c == ST_FIN_WAIT1 && !itm.seg_ack) ?
                                  EV_NONE : EV_CLOSED)};
              n_c        = n_c + 2'd1;
            end
            ST_ESTAB, ST_CLOSE_WAIT: begin
              res_c[n_c] = '{pkt: PK_ACK, seq: send_seq_nxt, ack: expect_seq_nxt,
                             ev: EV_NONE};
              n_c        = n_c + 2'd1;
              if (!itm.send_data_pending) begin
                res_c[n_c] = '{pkt: PK_FIN, seq: send_seq_nxt, ack: expect_seq_nxt,
                               ev: EV_CLOSED};
                n_c        = n_c + 2'd1;
              end
            end
            default: begin
            end
          endcase
        end

        acc_c = seg_go_c && (itm.payload_len != 16'd0);
      end
      default: begin
      end
    endcase

    // nothing to report still yields one word
    if (n_c == 2'd0) begin
      res_c[0] = '{pkt: PK_NONE, seq: send_seq_nxt, ack: expect_seq_nxt, ev: EV_NONE};
      n_c      = 2'd1;
    end
  end

  assign bat.res = res_c;
  assign bat.cnt = n_c;
  assign bat.st  = st_nxt;
  assign bat.acc = acc_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_CLOSED;
      send_seq_r   <= '0;
      expect_seq_r <= '0;
      peer_seq_r   <= '0;
      ack_seen_r   <= '0;
      dup_r        <= '0;
      peer_win_r   <= '0;
      seg_size_r   <= DEFAULT_MSS_RST;
    end else if (ld) begin
      st_r         <= st_nxt;
      send_seq_r   <= send_seq_nxt;
      expect_seq_r <= expect_seq_nxt;
      peer_seq_r   <= peer_seq_nxt;
      ack_seen_r   <= ack_seen_nxt;
      dup_r        <= dup_nxt;
      peer_win_r   <= peer_win_nxt;
      seg_size_r   <= seg_size_nxt;
    end
  end

endmodule

@@ rtl/core/tcf_out_ser.sv @@
// Result register and serialiser: holds one batch and sends it a word a cycle while out_tready is high.
// Depends on tcf_pkg and tcp_connection_fsm_macros.svh.
`include "tcp_connection_fsm_macros.svh"

module tcf_out_ser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tcf_pkg::batch_t                 bat,
  input  logic                            bat_vld,
  output logic                            bat_take,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tcf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [2:0]                      out_tuser,
  output logic                            out_tlast
);
  import tcf_pkg::*;

  batch_t     bat_r;
  logic [1:0] idx_r;
  logic       vld_r;
  logic       last_c;
  logic       free_c;
  res_t       cur_c;

  assign cur_c    = bat_r.res[idx_r];
  assign last_c   = (idx_r == (bat_r.cnt - 2'd1));
  assign free_c   = !vld_r || (out_tready && last_c);
  assign bat_take = bat_vld && free_c;

  assign out_tvalid = vld_r;
  assign out_tdata  = {bat_r.acc, cur_c.ev, bat_r.st, cur_c.ack, cur_c.seq};
  assign out_tuser  = cur_c.pkt;
  assign out_tlast  = last_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (bat_take) begin
      vld_r <= 1'b1;
      idx_r <= 2'd0;
    end else if (vld_r && out_tready) begin
      if (last_c) begin
        vld_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bat_take) begin
      bat_r <= bat;
    end
  end

  `TCF_ASSERT_NOW(a_idx_in_batch, vld_r, (idx_r < bat_r.cnt) && (bat_r.cnt != 2'd0), "word index beyond batch")
  `TCF_ASSERT_NEXT(a_load_starts, bat_take, vld_r && (idx_r == 2'd0), "batch load did not restart index")
  `TCF_ASSERT_NEXT(a_drain_empty, vld_r && out_tready && last_c && !bat_take, !vld_r, "serialiser kept a drained batch")
  `TCF_ASSERT_NEXT(a_stall_hold, vld_r && !out_tready, vld_r && $stable(idx_r), "word index moved under stall")

endmodule

@@ rtl/core/tcp_connection_fsm.sv @@
// Top level of the TCP connection tracker: input register, step logic,
// result serialiser and the default MSS register. Depends on tcf_pkg.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+------------------------------------
//  in_     | in  | in_tvalid / in_tready    | tdata 152 b, tuser = command
//  out_    | out | out_tvalid / out_tready  | tdata 72 b, tuser = packet_kind, tlast
//  cfg_    | in  | cfg_tvalid / cfg_tready  | tdata = default_mss
//
// An input word yields one to three result words, sent one per cycle while out_tready
// is high; the first word passes the input register, then the result register. The
// result serialiser sets the rate: one result word per cycle, so single-word items
// flow every cycle while out_tready is high. Synchronous active-low reset clears the
// connection to closed and default_mss to 536. Low out_tready holds the current word;
// the input register still takes one more word while the serialiser is busy.
module tcp_connection_fsm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] initial_seq, [32] seg_syn, [33] seg_ack, [34] seg_fin,
  // [66:35] seg_seq, [98:67] seg_ack_num, [114:99] seg_window,
  // [130:115] payload_len, [131] mss_opt_present, [147:132] mss_opt_value,
  // [148] send_data_pending, [151:149] zero
  input  logic [tcf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] seq_out, [63:32] ack_out, [67:64] state_now, [70:68] event_code,
  // [71] payload_accept
  output logic [tcf_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [2:0] packet_kind
  output logic [2:0]                      out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_tvalid,
  output logic                            cfg_tready,
  // [15:0] default_mss
  input  logic [15:0]                     cfg_tdata
);
  import tcf_pkg::*;

  in_item_t    itm;
  logic        itm_vld;
  logic        take;
  batch_t      bat;
  logic [15:0] dflt_mss_r;

  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_mss_r <= DEFAULT_MSS_RST;
    end else if (cfg_tvalid && cfg_tready) begin
      dflt_mss_r <= cfg_tdata;
    end
  end

  tcf_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .itm       (itm),
    .itm_vld   (itm_vld),
    .itm_take  (take)
  );

  tcf_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .itm      (itm),
    .ld       (take),
    .dflt_mss (dflt_mss_r),
    .bat      (bat)
  );

  tcf_out_ser u_out_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .bat        (bat),
    .bat_vld    (itm_vld),
    .bat_take   (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
